[design/tpt_pkg.sv]
package tpt_pkg;

  localparam int TEMP_W   = 12;
  localparam int HYST_W   = 8;
  localparam int PERIOD_W = 8;
  localparam int GAIN_W   = 16;
  localparam int PHASE_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // error (12 bit, floored) times Q8 gain; Q4 and Q8 fractions drop out at bit 12
  localparam int ERR_W  = TEMP_W;
  localparam int PROD_W = ERR_W + GAIN_W;
  localparam int FRAC_W = 12;

  localparam logic signed [TEMP_W-1:0] SETPOINT_RESET = 12'sd720;
  localparam logic [HYST_W-1:0]        HYST_RESET     = 8'd16;
  localparam logic [PERIOD_W-1:0]      PERIOD_RESET   = 8'd100;
  localparam logic [GAIN_W-1:0]        GAIN_RESET     = 16'd448;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 2'd0,
    REG_HYST     = 2'd1,
    REG_PERIOD   = 2'd2,
    REG_GAIN     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_COOLING  = 2'd0,
    MODE_HEAT_ON  = 2'd1,
    MODE_HEAT_OFF = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic [HYST_W-1:0]        hysteresis;
    logic [PERIOD_W-1:0]      period_ticks;
    logic [GAIN_W-1:0]        gain;
  } cfg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] on_time;
    logic [PERIOD_W-1:0] rest_time;
  } period_t;

endpackage

[design/tpt_ifs.sv]
interface tpt_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [tpt_pkg::TEMP_W-1:0]  temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

interface tpt_result_if;
  logic                             valid;
  logic                             ready;
  logic                             heater_on;
  logic [1:0]                       mode;
  logic [tpt_pkg::PERIOD_W-1:0]     on_ticks;

  modport source (output valid, output heater_on, output mode, output on_ticks, input ready);
  modport sink   (input valid, input heater_on, input mode, input on_ticks, output ready);
endinterface

interface tpt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tpt_pkg::CFG_IDX_W-1:0]      index;
  logic [tpt_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/tpt_cfg_regs.sv]
module tpt_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  tpt_cfg_if.sink       cfg,
  output tpt_pkg::cfg_t regs
);
  import tpt_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setpoint     <= SETPOINT_RESET;
      regs.hysteresis   <= HYST_RESET;
      regs.period_ticks <= PERIOD_RESET;
      regs.gain         <= GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SETPOINT: regs.setpoint     <= signed'(cfg.data[TEMP_W-1:0]);
        REG_HYST:     regs.hysteresis   <= cfg.data[HYST_W-1:0];
        REG_PERIOD:   regs.period_ticks <= cfg.data[PERIOD_W-1:0];
        REG_GAIN:     regs.gain         <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/tpt_period_calc.sv]
module tpt_period_calc (
  input  logic signed [tpt_pkg::TEMP_W-1:0] temperature,
  input  tpt_pkg::cfg_t                     regs,
  output tpt_pkg::period_t                  period
);
  import tpt_pkg::*;

  logic signed [TEMP_W:0]      err;
  logic [ERR_W-1:0]            err_pos;
  logic [PROD_W-1:0]           prod;
  logic [PROD_W-FRAC_W-1:0]    scaled;
  logic [PERIOD_W-1:0]         on_time;

  always_comb begin
    err = (TEMP_W+1)'(regs.setpoint) - (TEMP_W+1)'(temperature);
    // above setpoint gives no on time
    err_pos = err[TEMP_W] ? '0 : err[ERR_W-1:0];
    prod    = PROD_W'(err_pos) * PROD_W'(regs.gain);
    scaled  = prod[PROD_W-1:FRAC_W];
    on_time = (scaled > (PROD_W-FRAC_W)'(regs.period_ticks)) ? regs.period_ticks
                                                             : scaled[PERIOD_W-1:0];
    period.on_time   = on_time;
    period.rest_time = regs.period_ticks - on_time;
  end

endmodule

[design/time_proportional_thermostat.sv]
// Time-proportional thermostat. Each sample beat is one control tick carrying a
// Q4 temperature; each tick yields exactly one result beat with heater drive, mode
// and the on time of the current modulation period. The block takes one tick per
// clock cycle while the result side does not stall. A tick goes into a sample
// register; from there the mode and counter update with the on-time multiply fills
// the result register, which offers its result beat; while the result side stalls
// the tick waits. The tick-to-tick dependency is only through the mode, phase
// counter and period registers, updated as a tick leaves the sample register.
// Configuration writes are taken in any cycle and must only happen while no tick
// is in flight; new period or gain values apply at the next start of an on phase.
module time_proportional_thermostat (
  input  logic        clk,
  input  logic        rst,
  tpt_sample_if.sink  sample,
  tpt_result_if.source result,
  tpt_cfg_if.sink     cfg
);
  import tpt_pkg::*;

  cfg_t    regs;
  period_t period;

  logic                     s1_valid;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     res_free;
  logic                     s1_move;

  mode_t                      mode, mode_next;
  logic signed [PHASE_W-1:0]  phase, phase_next, phase_dec;
  logic [PERIOD_W-1:0]        on_time, on_time_next;
  logic [PERIOD_W-1:0]        rest_time, rest_time_next;

  logic signed [TEMP_W+2:0]   temp2, sp2_half, sp_low;

  tpt_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tpt_period_calc u_period (
    .temperature (s1_temp),
    .regs        (regs),
    .period      (period)
  );

  assign res_free     = !result.valid || result.ready;
  assign s1_move      = s1_valid && res_free;
  assign sample.ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
    if (sample.valid && sample.ready) begin
      s1_temp <= sample.temperature;
    end
  end

  always_comb begin
    temp2    = (TEMP_W+3)'(s1_temp) <<< 1;
    // exact half band: 2*temp >= 2*setpoint - hysteresis
    sp2_half = ((TEMP_W+3)'(regs.setpoint) <<< 1) - (TEMP_W+3)'({1'b0, regs.hysteresis});
    sp_low   = (TEMP_W+3)'(regs.setpoint) - (TEMP_W+3)'({1'b0, regs.hysteresis});
    phase_dec = phase - PHASE_W'(1);

    mode_next      = mode;
    phase_next     = phase;
    on_time_next   = on_time;
    rest_time_next = rest_time;

    unique case (mode)
      MODE_HEAT_ON: begin
        phase_next = phase_dec;
        if (phase_dec <= 0) begin
          mode_next  = MODE_HEAT_OFF;
          phase_next = signed'(PHASE_W'(rest_time));
        end else if (temp2 >= sp2_half) begin
          mode_next = MODE_COOLING;
        end
      end
      MODE_HEAT_OFF: begin
        phase_next = phase_dec;
        if (phase_dec <= 0) begin
          mode_next      = MODE_HEAT_ON;
          on_time_next   = period.on_time;
          rest_time_next = period.rest_time;
          phase_next     = signed'(PHASE_W'(period.on_time));
        end else if (s1_temp >= regs.setpoint) begin
          mode_next = MODE_COOLING;
        end
      end
      default: begin
        mode_next = MODE_COOLING;
        if ((TEMP_W+3)'(s1_temp) < sp_low) begin
          mode_next      = MODE_HEAT_ON;
          on_time_next   = period.on_time;
          rest_time_next = period.rest_time;
          phase_next     = signed'(PHASE_W'(period.on_time));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_COOLING;
      phase        <= '0;
      on_time      <= PERIOD_RESET;
      rest_time    <= PERIOD_RESET;
      result.valid <= 1'b0;
    end else begin
      if (res_free) begin
        result.valid <= s1_valid;
      end
      if (s1_move) begin
        mode      <= mode_next;
        phase     <= phase_next;
        on_time   <= on_time_next;
        rest_time <= rest_time_next;
      end
    end
    if (s1_move) begin
      result.heater_on <= (mode_next == MODE_HEAT_ON);
      result.mode      <= mode_next;
      result.on_ticks  <= on_time_next;
    end
  end

`ifndef SYNTH
  // a tick in the sample register always lands in the result register next
  a_tick_lands: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> result.valid)
    else $error("tick lost between sample and result register");

  // input only stalls when both stages are full and the output is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (s1_valid && result.valid && !result.ready))
    else $error("sample stalled without back-pressure");

  // the phase counter never runs below one tick past zero
  a_phase_floor: assert property (@(posedge clk) disable iff (rst)
    phase >= -9'sd1)
    else $error("phase counter underflow");
`endif

endmodule
